// ===== design/cdrl_pkg.sv =====
package cdrl_pkg;

    // Fixed formats of the restraint terms
    localparam int COORD_W  = 24;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int TGT_W    = 16;
    localparam int WGT_W    = 16;
    localparam int RAD_W    = 31;
    localparam int ROOT_W   = 32;
    localparam int ERRSQ_W  = 2 * TGT_W;
    localparam int PROD_W   = ERRSQ_W + WGT_W;
    localparam int FRAC_CUT = 12;
    localparam int TERM_W   = PROD_W - FRAC_CUT;
    localparam int LOSS_W   = 64;

    // 10.0 angstrom in Q12, and its square in Q24
    localparam logic [TGT_W-1:0] CLAMP_Q12 = 16'd40960;
    localparam logic [SQ_W-1:0]  CLAMP_SQ  = 50'd1677721600;

    localparam int QUEUE_DEPTH = 2;

    // One classified term on its way from the front to the back
    typedef struct packed {
        logic [RAD_W-1:0] radicand;
        logic             clamp;
        logic [TGT_W-1:0] target;
        logic [WGT_W-1:0] weight;
        logic             last;
    } job_t;

endpackage

// ===== design/clamped_distance_restraint_loss_unit.sv =====
// Clamped distance restraint loss unit.
// Input channel (in_valid / in_ready): one restraint term per word, a query
// point, a pocket atom, the pair's target distance, weight and last_term mark.
// Output channel (out_valid / out_ready): one total_loss word per term that
// carries last_term, holding the weighted sum of all terms since the previous
// one and saturating at all ones. Terms without the mark give no word.
// A front stage takes a word, squares the three axis differences on one
// shared multiplier and posts the result into a small queue, waiting while
// the queue is full; the back stage runs a 16-step square root, then error,
// square, weight multiply and accumulate, one term at a time. The back stage,
// above all its square root loop, sets the sustained term rate; the front
// takes a new word only after it has posted the last one.
// Reset clears the running sum, the queue and both stages. While out_ready
// is low a finished sum waits in the output register; the back stage stops
// only at the next last term, and the front keeps taking words until the
// queue fills.
module clamped_distance_restraint_loss_unit
#(
    parameter int QUEUE_DEPTH = cdrl_pkg::QUEUE_DEPTH
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [cdrl_pkg::COORD_W-1:0]   query_x,
    input  logic signed [cdrl_pkg::COORD_W-1:0]   query_y,
    input  logic signed [cdrl_pkg::COORD_W-1:0]   query_z,
    input  logic signed [cdrl_pkg::COORD_W-1:0]   pocket_x,
    input  logic signed [cdrl_pkg::COORD_W-1:0]   pocket_y,
    input  logic signed [cdrl_pkg::COORD_W-1:0]   pocket_z,
    input  logic        [cdrl_pkg::TGT_W-1:0]     target_distance,
    input  logic        [cdrl_pkg::WGT_W-1:0]     weight,
    input  logic                                  last_term,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic        [cdrl_pkg::LOSS_W-1:0]    total_loss
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    cdrl_pkg::job_t q_wdata;
    cdrl_pkg::job_t q_rdata;

    cdrl_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .query_x         (query_x),
        .query_y         (query_y),
        .query_z         (query_z),
        .pocket_x        (pocket_x),
        .pocket_y        (pocket_y),
        .pocket_z        (pocket_z),
        .target_distance (target_distance),
        .weight          (weight),
        .last_term       (last_term),
        .q_push          (q_push),
        .q_wdata         (q_wdata),
        .q_full          (q_full)
    );

    cdrl_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    cdrl_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_pop      (q_pop),
        .q_rdata    (q_rdata),
        .q_empty    (q_empty),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .total_loss (total_loss)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("front pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back popped an empty queue");

    a_pop_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty && !q_push |=> !q_pop)
        else $error("back took a word that was never queued");

endmodule

// ===== design/cdrl_front.sv =====
module cdrl_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [cdrl_pkg::COORD_W-1:0]   query_x,
    input  logic signed [cdrl_pkg::COORD_W-1:0]   query_y,
    input  logic signed [cdrl_pkg::COORD_W-1:0]   query_z,
    input  logic signed [cdrl_pkg::COORD_W-1:0]   pocket_x,
    input  logic signed [cdrl_pkg::COORD_W-1:0]   pocket_y,
    input  logic signed [cdrl_pkg::COORD_W-1:0]   pocket_z,
    input  logic        [cdrl_pkg::TGT_W-1:0]     target_distance,
    input  logic        [cdrl_pkg::WGT_W-1:0]     weight,
    input  logic                                  last_term,
    output logic                                  q_push,
    output cdrl_pkg::job_t                        q_wdata,
    input  logic                                  q_full
);

    typedef enum logic [1:0] {F_IDLE, F_SQ, F_PUSH} state_t;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Z = 2'd2;

    state_t                          state_reg;
    logic [cdrl_pkg::DIFF_W-1:0]     diff_reg [3];
    logic [1:0]                      axis_reg;
    logic [cdrl_pkg::SQ_W-1:0]       acc_reg;
    logic [cdrl_pkg::TGT_W-1:0]      target_reg;
    logic [cdrl_pkg::WGT_W-1:0]      weight_reg;
    logic                            last_reg;
    logic [cdrl_pkg::DIFF_W-1:0]     cur_diff;
    logic [cdrl_pkg::SQ_W-1:0]       cur_sq;

    function automatic logic [cdrl_pkg::DIFF_W-1:0] abs_diff(
        input logic [cdrl_pkg::COORD_W-1:0] a,
        input logic [cdrl_pkg::COORD_W-1:0] b
    );
        logic [cdrl_pkg::DIFF_W-1:0] d;
        d = {a[cdrl_pkg::COORD_W-1], a} - {b[cdrl_pkg::COORD_W-1], b};
        return d[cdrl_pkg::DIFF_W-1] ? (~d + 1'b1) : d;
    endfunction

    assign in_ready = (state_reg == F_IDLE);

    // One shared multiplier squares the three axes in turn
    assign cur_diff = diff_reg[axis_reg];
    assign cur_sq   = {{cdrl_pkg::DIFF_W{1'b0}}, cur_diff}
                    * {{cdrl_pkg::DIFF_W{1'b0}}, cur_diff};

    assign q_push            = (state_reg == F_PUSH) && !q_full;
    assign q_wdata.radicand  = acc_reg[cdrl_pkg::RAD_W-1:0];
    assign q_wdata.clamp     = (acc_reg >= cdrl_pkg::CLAMP_SQ);
    assign q_wdata.target    = target_reg;
    assign q_wdata.weight    = weight_reg;
    assign q_wdata.last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            axis_reg   <= AXIS_X;
            acc_reg    <= '0;
            target_reg <= '0;
            weight_reg <= '0;
            last_reg   <= 1'b0;
            diff_reg   <= '{default: '0};
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        diff_reg[0] <= abs_diff(query_x, pocket_x);
                        diff_reg[1] <= abs_diff(query_y, pocket_y);
                        diff_reg[2] <= abs_diff(query_z, pocket_z);
                        target_reg  <= target_distance;
                        weight_reg  <= weight;
                        last_reg    <= last_term;
                        acc_reg     <= '0;
                        axis_reg    <= AXIS_X;
                        state_reg   <= F_SQ;
                    end
                end
                F_SQ:
                begin
                    acc_reg <= acc_reg + cur_sq;
                    if (axis_reg == AXIS_Z)
                    begin
                        state_reg <= F_PUSH;
                    end
                    else
                    begin
                        axis_reg <= axis_reg + 2'd1;
                    end
                end
                F_PUSH:
                begin
                    // hold the word until the queue has room
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/cdrl_queue.sv =====
module cdrl_queue
#(
    parameter int DEPTH = cdrl_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cdrl_pkg::job_t wdata,
    output logic           full,
    input  logic           pop,
    output cdrl_pkg::job_t rdata,
    output logic           empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cdrl_pkg::job_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/cdrl_back.sv =====
module cdrl_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    output logic                              q_pop,
    input  cdrl_pkg::job_t                    q_rdata,
    input  logic                              q_empty,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cdrl_pkg::LOSS_W-1:0]       total_loss
);

    typedef enum logic [2:0] {B_IDLE, B_ROOT, B_ERR, B_SQR, B_MUL, B_ACC} state_t;

    localparam logic [cdrl_pkg::RAD_W-1:0] BIT_START =
        {1'b1, {(cdrl_pkg::RAD_W-1){1'b0}}};

    state_t                           state_reg;
    cdrl_pkg::job_t                   job_reg;
    logic [cdrl_pkg::RAD_W-1:0]       rem_reg;
    logic [cdrl_pkg::ROOT_W-1:0]      res_reg;
    logic [cdrl_pkg::RAD_W-1:0]       bit_reg;
    logic [cdrl_pkg::TGT_W-1:0]       err_reg;
    logic [cdrl_pkg::ERRSQ_W-1:0]     errsq_reg;
    logic [cdrl_pkg::TERM_W-1:0]      term_reg;
    logic [cdrl_pkg::LOSS_W-1:0]      loss_sum_reg;
    logic                             out_valid_reg;
    logic [cdrl_pkg::LOSS_W-1:0]      total_loss_reg;

    logic [cdrl_pkg::ROOT_W-1:0]      trial;
    logic                             take;
    logic [cdrl_pkg::TGT_W-1:0]       dist_q12;
    logic [cdrl_pkg::PROD_W-1:0]      prod;
    logic [cdrl_pkg::LOSS_W:0]        sum_wide;
    logic [cdrl_pkg::LOSS_W-1:0]      sum_sat;
    logic                             can_emit;
    logic                             emit;

    assign q_pop      = (state_reg == B_IDLE) && !q_empty;
    assign out_valid  = out_valid_reg;
    assign total_loss = total_loss_reg;

    // One root bit per step
    assign trial = res_reg + {1'b0, bit_reg};
    assign take  = ({1'b0, rem_reg} >= trial);

    assign dist_q12 = job_reg.clamp ? cdrl_pkg::CLAMP_Q12 : res_reg[cdrl_pkg::TGT_W-1:0];
    assign prod = {{cdrl_pkg::WGT_W{1'b0}}, errsq_reg}
                * {{cdrl_pkg::ERRSQ_W{1'b0}}, job_reg.weight};

    assign sum_wide = {1'b0, loss_sum_reg}
                    + {{(cdrl_pkg::LOSS_W + 1 - cdrl_pkg::TERM_W){1'b0}}, term_reg};
    assign sum_sat  = sum_wide[cdrl_pkg::LOSS_W] ? '1 : sum_wide[cdrl_pkg::LOSS_W-1:0];
    assign can_emit = !out_valid_reg || out_ready;
    assign emit     = (state_reg == B_ACC) && job_reg.last && can_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            job_reg        <= '0;
            rem_reg        <= '0;
            res_reg        <= '0;
            bit_reg        <= '0;
            err_reg        <= '0;
            errsq_reg      <= '0;
            term_reg       <= '0;
            loss_sum_reg   <= '0;
            out_valid_reg  <= 1'b0;
            total_loss_reg <= '0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        job_reg   <= q_rdata;
                        rem_reg   <= q_rdata.radicand;
                        res_reg   <= '0;
                        bit_reg   <= BIT_START;
                        state_reg <= B_ROOT;
                    end
                end
                B_ROOT:
                begin
                    if (take)
                    begin
                        rem_reg <= rem_reg - trial[cdrl_pkg::RAD_W-1:0];
                        res_reg <= (res_reg >> 1) + {1'b0, bit_reg};
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        state_reg <= B_ERR;
                    end
                end
                B_ERR:
                begin
                    err_reg   <= (job_reg.target >= dist_q12) ? (job_reg.target - dist_q12)
                                                              : (dist_q12 - job_reg.target);
                    state_reg <= B_SQR;
                end
                B_SQR:
                begin
                    errsq_reg <= {{cdrl_pkg::TGT_W{1'b0}}, err_reg}
                               * {{cdrl_pkg::TGT_W{1'b0}}, err_reg};
                    state_reg <= B_MUL;
                end
                B_MUL:
                begin
                    term_reg  <= prod[cdrl_pkg::PROD_W-1:cdrl_pkg::FRAC_CUT];
                    state_reg <= B_ACC;
                end
                B_ACC:
                begin
                    if (!job_reg.last)
                    begin
                        loss_sum_reg <= sum_sat;
                        state_reg    <= B_IDLE;
                    end
                    else if (can_emit)
                    begin
                        // emit the closed sum and clear it
                        total_loss_reg <= sum_sat;
                        loss_sum_reg   <= '0;
                        state_reg      <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule
